// ===== sv/integer_pixel_replication_scaler_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef INTEGER_PIXEL_REPLICATION_SCALER_TOP_ASSERT_SVH
`define INTEGER_PIXEL_REPLICATION_SCALER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipr assertion failed");

// Next-cycle implication, disabled during reset.
`define IPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipr assertion failed");

`endif

// ===== sv/ipr_pkg.sv =====
`timescale 1ns / 1ps
package ipr_pkg;

  localparam int MAX_ROW_WIDTH = 1024;
  localparam int MAX_SCALE     = 100;

  localparam int ADDR_W  = $clog2(MAX_ROW_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int SCALE_W = 7;
  localparam int PIXEL_W = 24;
  localparam int PAD_W   = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = CFG_INDEX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic               op;
    logic [PIXEL_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] run_pixel;
    logic [SCALE_W-1:0] run_length;
    logic               row_end;
    logic [PAD_W-1:0]   pad_bytes;
    logic               rejected;
  } out_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] pixel;
    logic [SCALE_W-1:0] len;
    logic               row_end;
    logic [PAD_W-1:0]   pad;
  } cmd_t;

endpackage

// ===== sv/ipr_queue.sv =====
`timescale 1ns / 1ps
module ipr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ipr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ipr_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import ipr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/ipr_front.sv =====
`timescale 1ns / 1ps
module ipr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ipr_pkg::in_t                    item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_full,
  output logic                            push,
  output ipr_pkg::cmd_t                   push_cmd
);
  import ipr_pkg::*;

  logic [SCALE_W-1:0] scale;
  logic [WIDTH_W-1:0] row_width;
  logic [ADDR_W-1:0]  col;
  logic [ADDR_W-1:0]  col_next;
  logic [ADDR_W-1:0]  rcol;
  logic [ADDR_W-1:0]  rcol_next;
  logic [SCALE_W-1:0] passes;
  logic [SCALE_W-1:0] passes_next;
  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [PAD_W-1:0]   pad;
  logic [WIDTH_W-1:0] col_inc;
  logic [WIDTH_W-1:0] rcol_inc;
  logic               accept;

  assign cfg_ready  = 1'b1;
  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    if (scale == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale;
    end
    if (row_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (row_width > WIDTH_W'(MAX_ROW_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = row_width;
    end
  end

  // The row is 3*w*s bytes, so the padding to a 4-byte boundary is w*s mod 4.
  assign pad      = PAD_W'(w_eff[PAD_W-1:0] * s_eff[PAD_W-1:0]);
  assign col_inc  = WIDTH_W'(col) + WIDTH_W'(1);
  assign rcol_inc = WIDTH_W'(rcol) + WIDTH_W'(1);

  always_comb begin
    push          = 1'b0;
    push_cmd      = '0;
    push_cmd.kind = CMD_REJECT;
    col_next      = col;
    rcol_next     = rcol;
    passes_next   = passes;
    if (accept) begin
      if (item.op == OP_PIXEL) begin
        push = 1'b1;
        if (passes == '0) begin
          push_cmd.kind  = CMD_WRITE;
          push_cmd.addr  = col;
          push_cmd.pixel = item.pixel;
          push_cmd.len   = s_eff;
          if (col_inc >= w_eff) begin
            push_cmd.row_end = 1'b1;
            push_cmd.pad     = pad;
            col_next         = '0;
            rcol_next        = '0;
            passes_next      = s_eff - SCALE_W'(1);
          end else begin
            col_next = ADDR_W'(col_inc);
          end
        end
      end else if (passes != '0) begin
        push          = 1'b1;
        push_cmd.kind = CMD_READ;
        push_cmd.addr = rcol;
        push_cmd.len  = s_eff;
        if (rcol_inc >= w_eff) begin
          push_cmd.row_end = 1'b1;
          push_cmd.pad     = pad;
          rcol_next        = '0;
          passes_next      = passes - SCALE_W'(1);
        end else begin
          rcol_next = ADDR_W'(rcol_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_W'(1);
      row_width <= WIDTH_W'(1);
      col       <= '0;
      rcol      <= '0;
      passes    <= '0;
    end else begin
      col    <= col_next;
      rcol   <= rcol_next;
      passes <= passes_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE: begin
            scale <= cfg_data[SCALE_W-1:0];
          end
          REG_ROW_WIDTH: begin
            row_width <= cfg_data[WIDTH_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/ipr_back.sv =====
`timescale 1ns / 1ps
module ipr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ipr_pkg::cmd_t head,
  output logic          pop,
  output logic          run_valid,
  input  logic          run_stall,
  output ipr_pkg::out_t run
);
  import ipr_pkg::*;

  logic [PIXEL_W-1:0] row_store [MAX_ROW_WIDTH];
  logic [PIXEL_W-1:0] rd_data;
  cmd_t               cur;

  assign pop = !q_empty && (!run_valid || !run_stall);

  // Single-port row store: a write command writes it, a read command reads it, and a reject leaves it alone.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == CMD_WRITE) begin
        row_store[head.addr] <= head.pixel;
      end else if (head.kind == CMD_READ) begin
        rd_data <= row_store[head.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (pop) begin
      run_valid <= 1'b1;
    end else if (!run_stall) begin
      run_valid <= 1'b0;
    end
  end

  always_comb begin
    run.run_length = cur.len;
    run.row_end    = cur.row_end;
    run.pad_bytes  = cur.pad;
    run.rejected   = 1'b0;
    case (cur.kind)
      CMD_READ: begin
        run.run_pixel = rd_data;
      end
      CMD_REJECT: begin
        run.run_pixel = cur.pixel;
        run.rejected  = 1'b1;
      end
      default: begin
        run.run_pixel = cur.pixel;
      end
    endcase
  end

endmodule

// ===== sv/integer_pixel_replication_scaler_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// item     item_valid / item_stall  item (op, pixel)
// run      run_valid / run_stall    run (run_pixel, run_length, row_end, pad_bytes, rejected)
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is taken per clock while item_stall is low; run_valid rises once the item's command
// has been written to the queue, popped, and registered in the back end's output register.
// The single-port row store is touched at most once per transaction, which sets that rate.
// Reset is synchronous; the row store is not cleared and holds garbage until written.
// A four-entry command queue lets the front keep taking items while run is stalled, until the queue fills.
module integer_pixel_replication_scaler_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  ipr_pkg::in_t                    item,
  output logic                            run_valid,
  input  logic                            run_stall,
  output ipr_pkg::out_t                   run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipr_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  ipr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ipr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ipr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .run_valid (run_valid),
    .run_stall (run_stall),
    .run       (run)
  );

endmodule

// ===== sv/ipr_checker.sv =====
`timescale 1ns / 1ps
`include "integer_pixel_replication_scaler_top_assert.svh"
module ipr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_stall,
  input ipr_pkg::in_t                    item,
  input logic                            run_valid,
  input logic                            run_stall,
  input ipr_pkg::out_t                   run,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ipr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ipr_pkg::*;

  // A dropped pixel carries no run and no row end.
  `IPR_ASSERT_NOW(a_reject_empty, run_valid && run.rejected,
    run.run_length == '0 && !run.row_end && run.pad_bytes == '0 && run.run_pixel == '0)

  // Every accepted run repeats its pixel at least once.
  `IPR_ASSERT_NOW(a_run_nonzero, run_valid && !run.rejected, run.run_length != '0)

  // Padding is reported only where an output row ends.
  `IPR_ASSERT_NOW(a_pad_row_end, run_valid && !run.row_end, run.pad_bytes == '0)

  // A stalled result stays presented unchanged.
  `IPR_ASSERT_NEXT(a_run_hold, run_valid && run_stall, run_valid && $stable(run))

endmodule

bind integer_pixel_replication_scaler_top ipr_checker u_checker (.*);
